// ----- src/tskf_pkg.sv -----
package tskf_pkg;

   localparam int WORD_BITS = 48;
   localparam int FRAC_BITS = 32;
   localparam int NUM_BITS  = WORD_BITS + FRAC_BITS;
   localparam int CNT_BITS  = 7;
   localparam int STEP_BITS = 5;
   localparam int NUM_STEPS = 28;
   localparam int MUL_LAST  = 3;
   localparam int DIV_LAST  = NUM_BITS + 1;

   localparam logic [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam logic [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};
   localparam logic [WORD_BITS-1:0] ONE  = WORD_BITS'(64'd1 << FRAC_BITS);

   localparam logic [1:0] REG_TIME_STEP = 2'd0;
   localparam logic [1:0] REG_QP        = 2'd1;
   localparam logic [1:0] REG_QV        = 2'd2;
   localparam logic [1:0] REG_R         = 2'd3;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef enum logic [4:0] {
      R_X0  = 5'd0,
      R_X1  = 5'd1,
      R_P00 = 5'd2,
      R_P01 = 5'd3,
      R_P10 = 5'd4,
      R_P11 = 5'd5,
      R_DT  = 5'd6,
      R_QP  = 5'd7,
      R_QV  = 5'd8,
      R_R   = 5'd9,
      R_Z   = 5'd10,
      R_T   = 5'd11,
      R_A   = 5'd12,
      R_B   = 5'd13,
      R_S   = 5'd14,
      R_K0  = 5'd15,
      R_K1  = 5'd16,
      R_Y   = 5'd17
   } sel_type;

   typedef struct packed {
      op_type  op;
      sel_type a;
      sel_type b;
      sel_type dst;
   } uop_type;

   typedef struct packed {
      logic    start;
      uop_type uop;
      logic    load_z;
      logic    load_out;
   } cmd_type;

   typedef struct packed {
      logic done;
   } status_type;

   typedef struct packed {
      logic [32:0] dt;
      logic [46:0] qp;
      logic [46:0] qv;
      logic [46:0] r;
   } cfg_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] val;
      logic                 sat;
   } sat_type;

   // predict, then correct; T holds the last product
   function automatic uop_type prog(input logic [STEP_BITS-1:0] step);
      uop_type u;
      u = '{OP_ADD, R_X0, R_X0, R_X0};
      unique case (step)
         5'd0:  u = '{OP_MUL, R_DT,  R_X1,  R_T};
         5'd1:  u = '{OP_ADD, R_X0,  R_T,   R_X0};
         5'd2:  u = '{OP_MUL, R_DT,  R_P10, R_T};
         5'd3:  u = '{OP_ADD, R_P00, R_T,   R_A};
         5'd4:  u = '{OP_MUL, R_DT,  R_P11, R_T};
         5'd5:  u = '{OP_ADD, R_P01, R_T,   R_B};
         5'd6:  u = '{OP_MUL, R_B,   R_DT,  R_T};
         5'd7:  u = '{OP_ADD, R_A,   R_T,   R_A};
         5'd8:  u = '{OP_ADD, R_A,   R_QP,  R_A};
         5'd9:  u = '{OP_MUL, R_P11, R_DT,  R_T};
         5'd10: u = '{OP_ADD, R_P10, R_T,   R_P10};
         5'd11: u = '{OP_ADD, R_P11, R_QV,  R_P11};
         5'd12: u = '{OP_ADD, R_A,   R_R,   R_S};
         5'd13: u = '{OP_DIV, R_A,   R_S,   R_K0};
         5'd14: u = '{OP_DIV, R_P10, R_S,   R_K1};
         5'd15: u = '{OP_SUB, R_Z,   R_X0,  R_Y};
         5'd16: u = '{OP_MUL, R_K0,  R_Y,   R_T};
         5'd17: u = '{OP_ADD, R_X0,  R_T,   R_X0};
         5'd18: u = '{OP_MUL, R_K1,  R_Y,   R_T};
         5'd19: u = '{OP_ADD, R_X1,  R_T,   R_X1};
         5'd20: u = '{OP_MUL, R_K0,  R_A,   R_T};
         5'd21: u = '{OP_SUB, R_A,   R_T,   R_P00};
         5'd22: u = '{OP_MUL, R_K0,  R_B,   R_T};
         5'd23: u = '{OP_SUB, R_B,   R_T,   R_P01};
         5'd24: u = '{OP_MUL, R_K1,  R_A,   R_T};
         5'd25: u = '{OP_SUB, R_P10, R_T,   R_P10};
         5'd26: u = '{OP_MUL, R_K1,  R_B,   R_T};
         5'd27: u = '{OP_SUB, R_P11, R_T,   R_P11};
         default: u = '{OP_ADD, R_X0, R_X0, R_X0};
      endcase
      return u;
   endfunction

   // sign a magnitude and clamp it to the word
   function automatic sat_type sat_mag(input logic [NUM_BITS:0] m, input logic neg);
      sat_type res;
      logic [NUM_BITS:0] lim;
      lim = neg ? (NUM_BITS+1)'(WMIN) : (NUM_BITS+1)'(WMAX);
      if (m > lim) begin
         res.sat = 1'b1;
         res.val = neg ? WMIN : WMAX;
      end else begin
         res.sat = 1'b0;
         res.val = neg ? (WORD_BITS'(0) - m[WORD_BITS-1:0]) : m[WORD_BITS-1:0];
      end
      return res;
   endfunction

endpackage

// ----- src/tskf_dpath.sv -----
module tskf_dpath (
   input  logic                          clock,
   input  logic                          reset,
   input  tskf_pkg::cmd_type             cmd,
   output tskf_pkg::status_type          status,
   input  tskf_pkg::cfg_type             cfg,
   input  logic [tskf_pkg::WORD_BITS-1:0] measurement,
   output logic [tskf_pkg::WORD_BITS-1:0] position_estimate,
   output logic [tskf_pkg::WORD_BITS-1:0] velocity_estimate,
   output logic                          overflow_flag
);
   import tskf_pkg::*;

   logic [WORD_BITS-1:0] x0_ff, x1_ff, p00_ff, p01_ff, p10_ff, p11_ff;
   logic [WORD_BITS-1:0] x0_in, x1_in, p00_in, p01_in, p10_in, p11_in;
   logic [WORD_BITS-1:0] z_ff, t_ff, a_ff, b_ff, s_ff, k0_ff, k1_ff, y_ff;
   logic [WORD_BITS-1:0] z_in, t_in, a_in, b_in, s_in, k0_in, k1_in, y_in;
   logic [WORD_BITS-1:0] pos_ff, vel_ff, pos_in, vel_in;
   logic                 flag_ff, flag_in, oflag_ff, oflag_in;
   uop_type              uop_ff, uop_in;
   logic                 busy_ff, busy_in, done_ff, done_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [2*WORD_BITS-1:0] acc_ff, acc_in;
   logic [NUM_BITS-1:0]  num_ff, num_in;
   logic [WORD_BITS-1:0] rem_ff, rem_in;

   logic [WORD_BITS-1:0] opa, opb, ma, mb, cfg_word;
   logic [15:0]          chunk;
   logic [63:0]          prod;
   logic [2*WORD_BITS-1:0] rounded;
   logic [WORD_BITS:0]   trial, sum;
   logic                 qbit, dpos, neg, wr_en;
   logic                 rnd;
   sat_type              res;

   always_comb begin
      unique case (uop_ff.a)
         R_X0:  opa = x0_ff;
         R_X1:  opa = x1_ff;
         R_P00: opa = p00_ff;
         R_P01: opa = p01_ff;
         R_P10: opa = p10_ff;
         R_P11: opa = p11_ff;
         R_DT:  opa = WORD_BITS'(cfg.dt);
         R_QP:  opa = WORD_BITS'(cfg.qp);
         R_QV:  opa = WORD_BITS'(cfg.qv);
         R_R:   opa = WORD_BITS'(cfg.r);
         R_Z:   opa = z_ff;
         R_T:   opa = t_ff;
         R_A:   opa = a_ff;
         R_B:   opa = b_ff;
         R_S:   opa = s_ff;
         R_K0:  opa = k0_ff;
         R_K1:  opa = k1_ff;
         R_Y:   opa = y_ff;
         default: opa = '0;
      endcase
   end

   always_comb begin
      cfg_word = '0;
      unique case (uop_ff.b)
         R_X0:  opb = x0_ff;
         R_X1:  opb = x1_ff;
         R_P00: opb = p00_ff;
         R_P01: opb = p01_ff;
         R_P10: opb = p10_ff;
         R_P11: opb = p11_ff;
         R_DT:  opb = WORD_BITS'(cfg.dt);
         R_QP:  opb = WORD_BITS'(cfg.qp);
         R_QV:  opb = WORD_BITS'(cfg.qv);
         R_R:   opb = WORD_BITS'(cfg.r);
         R_Z:   opb = z_ff;
         R_T:   opb = t_ff;
         R_A:   opb = a_ff;
         R_B:   opb = b_ff;
         R_S:   opb = s_ff;
         R_K0:  opb = k0_ff;
         R_K1:  opb = k1_ff;
         R_Y:   opb = y_ff;
         default: opb = cfg_word;
      endcase
   end

   always_comb begin
      ma   = opa[WORD_BITS-1] ? (WORD_BITS'(0) - opa) : opa;
      mb   = opb[WORD_BITS-1] ? (WORD_BITS'(0) - opb) : opb;
      dpos = !opb[WORD_BITS-1] && (opb != '0);
      unique case (cnt_ff[1:0])
         2'd0:    chunk = mb[47:32];
         2'd1:    chunk = mb[31:16];
         default: chunk = mb[15:0];
      endcase
      prod    = 64'(ma) * 64'(chunk);
      rounded = acc_ff + (2*WORD_BITS)'(64'd1 << (FRAC_BITS - 1));
      trial   = {rem_ff, num_ff[NUM_BITS-1]};
      qbit    = trial >= {1'b0, opb};
      rnd     = rem_ff >= (opb - rem_ff);
      if (uop_ff.op == OP_SUB)
         sum = {opa[WORD_BITS-1], opa} - {opb[WORD_BITS-1], opb};
      else
         sum = {opa[WORD_BITS-1], opa} + {opb[WORD_BITS-1], opb};
   end

   // sequencing of the arithmetic unit
   always_comb begin
      uop_in  = uop_ff;
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      done_in = 1'b0;
      wr_en   = 1'b0;
      neg     = opa[WORD_BITS-1] ^ opb[WORD_BITS-1];
      res     = '{val: '0, sat: 1'b0};
      if (cmd.start) begin
         uop_in  = cmd.uop;
         busy_in = 1'b1;
         cnt_in  = '0;
         acc_in  = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 1'b1;
         unique case (uop_ff.op)
            OP_ADD, OP_SUB: begin
               wr_en = 1'b1;
               if (sum[WORD_BITS] != sum[WORD_BITS-1])
                  res = '{val: (sum[WORD_BITS] ? WMIN : WMAX), sat: 1'b1};
               else
                  res = '{val: sum[WORD_BITS-1:0], sat: 1'b0};
            end
            OP_MUL: begin
               if (cnt_ff == CNT_BITS'(MUL_LAST)) begin
                  wr_en = 1'b1;
                  res   = sat_mag((NUM_BITS+1)'(rounded[2*WORD_BITS-1:FRAC_BITS]), neg);
               end else begin
                  acc_in = (acc_ff << 16) + (2*WORD_BITS)'(prod);
               end
            end
            OP_DIV: begin
               neg = opa[WORD_BITS-1];
               if (cnt_ff == '0) begin
                  if (!dpos) begin
                     wr_en = 1'b1;
                     res   = '{val: '0, sat: 1'b1};
                  end else begin
                     num_in = {ma, {FRAC_BITS{1'b0}}};
                     rem_in = '0;
                  end
               end else if (cnt_ff == CNT_BITS'(DIV_LAST)) begin
                  wr_en = 1'b1;
                  res   = sat_mag({1'b0, num_ff} + (NUM_BITS+1)'(rnd), neg);
               end else begin
                  rem_in = qbit ? WORD_BITS'(trial - {1'b0, opb}) : trial[WORD_BITS-1:0];
                  num_in = {num_ff[NUM_BITS-2:0], qbit};
               end
            end
            default: wr_en = 1'b0;
         endcase
         if (wr_en) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_comb begin
      x0_in = x0_ff; x1_in = x1_ff; p00_in = p00_ff; p01_in = p01_ff;
      p10_in = p10_ff; p11_in = p11_ff; t_in = t_ff; a_in = a_ff; b_in = b_ff;
      s_in = s_ff; k0_in = k0_ff; k1_in = k1_ff; y_in = y_ff;
      z_in    = cmd.load_z ? measurement : z_ff;
      flag_in = cmd.load_z ? 1'b0 : (flag_ff | (wr_en & res.sat));
      pos_in  = cmd.load_out ? x0_ff : pos_ff;
      vel_in  = cmd.load_out ? x1_ff : vel_ff;
      oflag_in = cmd.load_out ? flag_ff : oflag_ff;
      if (wr_en) begin
         unique case (uop_ff.dst)
            R_X0:  x0_in  = res.val;
            R_X1:  x1_in  = res.val;
            R_P00: p00_in = res.val;
            R_P01: p01_in = res.val;
            R_P10: p10_in = res.val;
            R_P11: p11_in = res.val;
            R_T:   t_in   = res.val;
            R_A:   a_in   = res.val;
            R_B:   b_in   = res.val;
            R_S:   s_in   = res.val;
            R_K0:  k0_in  = res.val;
            R_K1:  k1_in  = res.val;
            R_Y:   y_in   = res.val;
            default: t_in = t_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x0_ff   <= ONE;
         x1_ff   <= ONE;
         p00_ff  <= ONE;
         p01_ff  <= ONE;
         p10_ff  <= ONE;
         p11_ff  <= ONE;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         flag_ff <= 1'b0;
      end else begin
         x0_ff   <= x0_in;
         x1_ff   <= x1_in;
         p00_ff  <= p00_in;
         p01_ff  <= p01_in;
         p10_ff  <= p10_in;
         p11_ff  <= p11_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
         flag_ff <= flag_in;
      end
   end

   always_ff @(posedge clock) begin
      z_ff <= z_in; t_ff <= t_in; a_ff <= a_in; b_ff <= b_in; s_ff <= s_in;
      k0_ff <= k0_in; k1_ff <= k1_in; y_ff <= y_in;
      pos_ff <= pos_in; vel_ff <= vel_in; oflag_ff <= oflag_in;
      uop_ff <= uop_in; cnt_ff <= cnt_in; acc_ff <= acc_in;
      num_ff <= num_in; rem_ff <= rem_in;
   end

   assign status.done       = done_ff;
   assign position_estimate = pos_ff;
   assign velocity_estimate = vel_ff;
   assign overflow_flag     = oflag_ff;

   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      !(cmd.start && busy_ff)) else $error("operation issued while unit busy");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("done held over two cycles");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("done while still busy");

endmodule

// ----- src/tskf_ctrl.sv -----
module tskf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output tskf_pkg::cmd_type    cmd,
   input  tskf_pkg::status_type status
);
   import tskf_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_ISSUE = 4'b0010,
      S_WAIT  = 4'b0100,
      S_OUT   = 4'b1000
   } state_type;

   state_type             state_ff, state_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  accept;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      cmd.uop      = prog(step_ff);
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.load_z = 1'b1;
               step_in    = '0;
               state_in   = S_ISSUE;
            end
         end
         S_ISSUE: begin
            cmd.start = 1'b1;
            state_in  = S_WAIT;
         end
         S_WAIT: begin
            if (status.done) begin
               if (step_ff == STEP_BITS'(NUM_STEPS - 1)) begin
                  state_in = S_OUT;
               end else begin
                  step_in  = step_ff + 1'b1;
                  state_in = S_ISSUE;
               end
            end
         end
         S_OUT: begin
            // output register free or emptying this cycle
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_accept_issue: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_ISSUE) else $error("item accepted but not started");
   a_out_last: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_OUT |-> step_ff == STEP_BITS'(NUM_STEPS - 1))
      else $error("result before last step");
   a_load_out: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_valid_ff) else $error("result loaded without valid");

endmodule

// ----- src/two_state_kalman_filter.sv -----
// Two-state (position, velocity) Kalman filter, signed Q16.32 in 48 bits.
// One item is one position measurement; each gives one result with the
// corrected position and velocity and a flag for any saturation or a
// non-positive innovation variance. Items are handled one at a time. A
// shared arithmetic unit runs 28 sequenced operations: a multiply sums
// three 48x16 partial products plus rounding, and each of the two gain
// divisions is a bit-serial restoring divide of 80 steps plus setup and
// rounding; the divisions dominate. With a non-positive denominator both
// divisions end at once. A finished result waits in an output register
// while the next item is already accepted. Configuration sits at byte
// addresses 0, 8, 16 and 24 (time step, position noise, velocity noise,
// measurement noise); write only while no item is in flight.
module two_state_kalman_filter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [47:0] req_measurement,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [47:0] rsp_position_estimate,
   output logic [47:0] rsp_velocity_estimate,
   output logic        rsp_overflow_flag,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);
   import tskf_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   cmd_type    cmd;
   status_type status;
   logic       wr;

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (csr_paddr[4:3])
            REG_TIME_STEP: cfg_in.dt = csr_pwdata[32:0];
            REG_QP:        cfg_in.qp = csr_pwdata[46:0];
            REG_QV:        cfg_in.qv = csr_pwdata[46:0];
            REG_R:         cfg_in.r  = csr_pwdata[46:0];
            default:       cfg_in    = cfg_ff;
         endcase
      end
      unique case (csr_paddr[4:3])
         REG_TIME_STEP: csr_prdata = 64'(cfg_ff.dt);
         REG_QP:        csr_prdata = 64'(cfg_ff.qp);
         REG_QV:        csr_prdata = 64'(cfg_ff.qv);
         REG_R:         csr_prdata = 64'(cfg_ff.r);
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dt <= 33'd429496730;
         cfg_ff.qp <= 47'd4295;
         cfg_ff.qv <= 47'd4295;
         cfg_ff.r  <= 47'd4295;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tskf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   tskf_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .cfg               (cfg_ff),
      .measurement       (req_measurement),
      .position_estimate (rsp_position_estimate),
      .velocity_estimate (rsp_velocity_estimate),
      .overflow_flag     (rsp_overflow_flag)
   );

endmodule

// ----- tb/sv/tb_two_state_kalman_filter.sv -----
module tb_two_state_kalman_filter;
   timeunit 1ns;
   timeprecision 1ps;

   import tskf_pkg::*;

   localparam longint SMAX = 64'sd140737488355327;
   localparam longint SMIN = -64'sd140737488355328;
   localparam longint LIMIT_CYCLES = 10000000;
   localparam int N_RANDOM = 1160;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [47:0] req_measurement;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [47:0] rsp_position_estimate;
   logic [47:0] rsp_velocity_estimate;
   logic        rsp_overflow_flag;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [4:0]  csr_paddr;
   logic [63:0] csr_pwdata;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   two_state_kalman_filter dut (.*);

   typedef struct {
      logic [47:0] pos;
      logic [47:0] vel;
      logic        ovf;
   } estimate_type;

   estimate_type estimates_pending[$];
   longint      cycle_count;
   int          error_count;
   int          estimates_seen;
   int          ovf_seen;
   bit          hold_off_req;
   bit          in_hold_off;

   // filter state and registers mirrored in the testbench
   longint      f_x0, f_x1, f_p00, f_p01, f_p10, f_p11;
   logic [32:0] f_dt;
   logic [46:0] f_qp, f_qv, f_r;
   bit          f_sat;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic longint clamp(input longint v);
      if (v > SMAX) begin
         f_sat = 1'b1;
         return SMAX;
      end
      if (v < SMIN) begin
         f_sat = 1'b1;
         return SMIN;
      end
      return v;
   endfunction

   function automatic longint q_add(input longint a, input longint b);
      return clamp(a + b);
   endfunction

   function automatic longint q_sub(input longint a, input longint b);
      return clamp(a - b);
   endfunction

   // sign a rounded magnitude and clamp it
   function automatic longint signed_clamp(input logic [127:0] m, input bit neg);
      logic [127:0] lim;
      lim = neg ? 128'd140737488355328 : 128'd140737488355327;
      if (m > lim) begin
         f_sat = 1'b1;
         return neg ? SMIN : SMAX;
      end
      return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
   endfunction

   function automatic longint q_mul(input longint a, input longint b);
      logic [127:0] ua, ub, p;
      ua = (a < 0) ? 128'(-a) : 128'(a);
      ub = (b < 0) ? 128'(-b) : 128'(b);
      p = (ua * ub + (128'd1 << 31)) >> 32;
      return signed_clamp(p, (a < 0) != (b < 0));
   endfunction

   function automatic longint q_div(input longint n, input longint d);
      logic [127:0] un, q, rem;
      un = (n < 0) ? 128'(-n) : 128'(n);
      un = un << 32;
      q = un / 128'(d);
      rem = un % 128'(d);
      if (rem >= 128'(d) - rem) q = q + 1;
      return signed_clamp(q, n < 0);
   endfunction

   function automatic longint reg_word(input logic [46:0] v);
      return longint'({17'd0, v});
   endfunction

   function automatic void filter_reset();
      f_x0 = 64'sd4294967296;
      f_x1 = f_x0;
      f_p00 = f_x0;
      f_p01 = f_x0;
      f_p10 = f_x0;
      f_p11 = f_x0;
      f_dt = 33'd429496730;
      f_qp = 47'd4295;
      f_qv = 47'd4295;
      f_r = 47'd4295;
   endfunction

   function automatic estimate_type filter_step(input logic [47:0] meas);
      longint z, dt, x0, x1, a, b, p00, p01, p10, p11, s, k0, k1, y;
      estimate_type e;
      z = longint'($signed(meas));
      dt = longint'({31'd0, f_dt});
      k0 = 0;
      k1 = 0;
      f_sat = 1'b0;
      x0 = q_add(f_x0, q_mul(dt, f_x1));
      x1 = f_x1;
      a = q_add(f_p00, q_mul(dt, f_p10));
      b = q_add(f_p01, q_mul(dt, f_p11));
      p00 = q_add(q_add(a, q_mul(b, dt)), reg_word(f_qp));
      p01 = b;
      p10 = q_add(f_p10, q_mul(f_p11, dt));
      p11 = q_add(f_p11, reg_word(f_qv));
      s = q_add(p00, reg_word(f_r));
      if (s > 0) begin
         k0 = q_div(p00, s);
         k1 = q_div(p10, s);
      end else begin
         f_sat = 1'b1;
      end
      y = q_sub(z, x0);
      f_x0 = q_add(x0, q_mul(k0, y));
      f_x1 = q_add(x1, q_mul(k1, y));
      f_p00 = q_sub(p00, q_mul(k0, p00));
      f_p01 = q_sub(p01, q_mul(k0, p01));
      f_p10 = q_sub(p10, q_mul(k1, p00));
      f_p11 = q_sub(p11, q_mul(k1, p01));
      e.pos = f_x0[47:0];
      e.vel = f_x1[47:0];
      e.ovf = f_sat;
      return e;
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("timeout at %0t", $time);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // receiver: random stall, plus a long hold-off on request
   initial begin
      int gap;
      rsp_stall = 1'b0;
      in_hold_off = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req && !in_hold_off) begin
            in_hold_off <= 1'b1;
            rsp_stall <= 1'b1;
            repeat (3000) @(posedge clock);
            rsp_stall <= 1'b0;
            in_hold_off <= 1'b0;
         end else if ($urandom_range(0, 9) < 3) begin
            gap = ($urandom_range(0, 19) == 0) ? $urandom_range(50, 400) : $urandom_range(1, 4);
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      estimate_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         estimates_seen <= estimates_seen + 1;
         if (estimates_pending.size() == 0) begin
            $display("%0t: result with nothing expected, got pos %h vel %h ovf %b", $time,
                     rsp_position_estimate, rsp_velocity_estimate, rsp_overflow_flag);
            error_count <= error_count + 1;
         end else begin
            e = estimates_pending.pop_front();
            if (e.ovf) ovf_seen <= ovf_seen + 1;
            if (e.pos !== rsp_position_estimate) begin
               $display("%0t: position expected %h got %h", $time, e.pos,
                        rsp_position_estimate);
               error_count <= error_count + 1;
            end
            if (e.vel !== rsp_velocity_estimate) begin
               $display("%0t: velocity expected %h got %h", $time, e.vel,
                        rsp_velocity_estimate);
               error_count <= error_count + 1;
            end
            if (e.ovf !== rsp_overflow_flag) begin
               $display("%0t: overflow expected %b got %b", $time, e.ovf, rsp_overflow_flag);
               error_count <= error_count + 1;
            end
         end
      end
   end

   task automatic send_measurement(input logic [47:0] meas, input bit idle_ok);
      int gap;
      if (idle_ok && $urandom_range(0, 9) < 3) begin
         gap = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 600) : $urandom_range(1, 5);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_measurement <= meas;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      estimates_pending.push_back(filter_step(meas));
   endtask

   task automatic end_burst();
      req_valid <= 1'b0;
      while (estimates_pending.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 3'b000};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_TIME_STEP: f_dt = value[32:0];
         REG_QP: f_qp = value[46:0];
         REG_QV: f_qv = value[46:0];
         default: f_r = value[46:0];
      endcase
   endtask

   task automatic set_config(input logic [32:0] dt, input logic [46:0] qp,
                             input logic [46:0] qv, input logic [46:0] r);
      write_reg(REG_TIME_STEP, 64'(dt));
      write_reg(REG_QP, 64'(qp));
      write_reg(REG_QV, 64'(qv));
      write_reg(REG_R, 64'(r));
   endtask

   function automatic logic [47:0] rand_word();
      return 48'({$urandom(), $urandom()} >> 16);
   endfunction

   // track the current estimate with bounded noise, sometimes a wild sample
   function automatic logic [47:0] tracking_sample();
      longint noise;
      if ($urandom_range(0, 19) == 0) return rand_word();
      noise = longint'($signed(32'($urandom()))) >>> $urandom_range(0, 12);
      return 48'(clamp(f_x0 + noise));
   endfunction

   task automatic test_extremes();
      logic [47:0] corner[10];
      corner = '{48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 48'h0, 48'hFFFF_FFFF_FFFF,
                 48'h0001_0000_0000, 48'hFFFF_0000_0000, 48'h5555_5555_5555,
                 48'hAAAA_AAAA_AAAA, 48'h0000_0000_0001, 48'h7FFF_FFFF_FFFF};
      foreach (corner[i]) send_measurement(corner[i], 1'b0);
      end_burst();
   endtask

   task automatic test_register_extremes();
      // time step of one with big noise, then all zero, then a time step just under two
      set_config(33'h1_0000_0000, 47'h7FFF_FFFF_FFFF, 47'h7FFF_FFFF_FFFF, 47'h7FFF_FFFF_FFFF);
      for (int i = 0; i < 4; i++) send_measurement(rand_word(), 1'b0);
      end_burst();
      set_config(33'd0, 47'd0, 47'd0, 47'd0);
      for (int i = 0; i < 4; i++) send_measurement(rand_word(), 1'b0);
      end_burst();
      set_config(33'h1_FFFF_FFFF, 47'h5555_5555_5555, 47'h2AAA_AAAA_AAAA, 47'd1);
      for (int i = 0; i < 4; i++) send_measurement(rand_word(), 1'b0);
      end_burst();
   endtask

   task automatic test_random(input int count);
      for (int i = 0; i < count; i++) begin
         if (i % 200 == 0) begin
            end_burst();
            set_config(33'($urandom_range(0, 1) ? $urandom() : {$urandom(), 1'b0} >> 1),
                       47'({$urandom(), $urandom()} >> $urandom_range(17, 60)),
                       47'({$urandom(), $urandom()} >> $urandom_range(17, 60)),
                       47'({$urandom(), $urandom()} >> $urandom_range(17, 60)) | 47'd1);
         end
         send_measurement($urandom_range(0, 3) == 0 ? rand_word() : tracking_sample(),
                          (i / 100) % 3 != 1);
      end
      end_burst();
   endtask

   task automatic test_back_pressure();
      hold_off_req = 1'b1;
      for (int i = 0; i < 12; i++) send_measurement(tracking_sample(), 1'b0);
      hold_off_req = 1'b0;
      end_burst();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_measurement = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      cycle_count = 0;
      error_count = 0;
      estimates_seen = 0;
      ovf_seen = 0;
      hold_off_req = 1'b0;
      filter_reset();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_extremes();
      test_register_extremes();
      set_config(33'd429496730, 47'd4295, 47'd4295, 47'd4295);
      test_back_pressure();
      test_random(N_RANDOM);

      $display("covered %0d results (%0d with overflow) over several register settings,",
               estimates_seen, ovf_seen);
      $display("with extreme samples, random stalls and a long output hold-off");
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ----- files.f -----
src/tskf_pkg.sv
src/tskf_dpath.sv
src/tskf_ctrl.sv
src/two_state_kalman_filter.sv
tb/sv/tb_two_state_kalman_filter.sv
